// ----- src/plfs_pkg.sv -----
`default_nettype none
package plfs_pkg;

  localparam int FRAME_BYTES = 28;
  localparam int LED_COUNT   = 4;
  localparam int CHAN_COUNT  = 3 * LED_COUNT;
  localparam int LEVEL_W     = 16;
  localparam int FRAME_BITS  = 8 * FRAME_BYTES;
  localparam int COUNT_W     = $clog2(FRAME_BYTES + 1);
  localparam int LED_IDX_W   = $clog2(LED_COUNT);

  localparam logic [5:0] WRITE_CODE = 6'h25;

  localparam logic [4:0] FUNC_CTRL_RESET   = 5'd22;
  localparam logic [6:0] GLOBAL_BRT_RESET  = 7'd127;

  typedef enum logic [1:0] {
    REG_FUNC_CTRL    = 2'd0,
    REG_GLOBAL_RED   = 2'd1,
    REG_GLOBAL_GREEN = 2'd2,
    REG_GLOBAL_BLUE  = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    CMD_SET    = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic last;
  } plfs_stream_t;

endpackage
`default_nettype wire

// ----- src/pwm_led_frame_serializer_core.sv -----
// Set command: updates the addressed LED's levels, no output transaction.
// Update command: frame is captured at acceptance; the first byte is valid the next
// cycle; the 28 bytes leave one per cycle while m_tready is high, from a shift register.
// A new input transaction is taken the cycle after the last byte is accepted.
// Synchronous reset clears all channel levels to zero, function control to 22 and
// the global brightness registers to 127.
`default_nettype none
module pwm_led_frame_serializer_core
  import plfs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [55:0] s_tdata,  // led_index[1:0], red_level[17:2], green_level[33:18],
                                     // blue_level[49:34], zero pad
  input  wire logic       s_tuser,   // command
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // frame_byte[7:0]
  output logic            m_tlast,   // last_byte
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [6:0] cfg_data
);

  logic [LEVEL_W-1:0]   levels [CHAN_COUNT];
  logic [4:0]           func_ctrl;
  logic [6:0]           global_red;
  logic [6:0]           global_green;
  logic [6:0]           global_blue;
  logic [FRAME_BITS-1:0] frame;
  logic [LED_IDX_W-1:0] led_index;
  logic                 busy;
  logic                 in_accept;
  logic                 load;
  plfs_stream_t         status;

  assign led_index = s_tdata[1:0];
  assign in_accept = s_tvalid && s_tready;
  assign load      = in_accept && (cmd_t'(s_tuser) == CMD_UPDATE);
  assign s_tready  = !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      func_ctrl    <= FUNC_CTRL_RESET;
      global_red   <= GLOBAL_BRT_RESET;
      global_green <= GLOBAL_BRT_RESET;
      global_blue  <= GLOBAL_BRT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FUNC_CTRL:    func_ctrl    <= cfg_data[4:0];
        REG_GLOBAL_RED:   global_red   <= cfg_data;
        REG_GLOBAL_GREEN: global_green <= cfg_data;
        REG_GLOBAL_BLUE:  global_blue  <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHAN_COUNT; i++) begin
        levels[i] <= '0;
      end
    end else if (in_accept && (cmd_t'(s_tuser) == CMD_SET)) begin
      for (int n = 0; n < LED_COUNT; n++) begin
        if (led_index == LED_IDX_W'(n)) begin
          levels[3*n]     <= s_tdata[17:2];
          levels[3*n + 1] <= s_tdata[33:18];
          levels[3*n + 2] <= s_tdata[49:34];
        end
      end
    end
  end

  always_comb begin
    frame[FRAME_BITS-1 -: 32] = {WRITE_CODE, func_ctrl, global_blue, global_green, global_red};
    for (int i = 0; i < CHAN_COUNT; i++) begin
      frame[LEVEL_W*i +: LEVEL_W] = levels[i];
    end
  end

  plfs_frame_shifter u_shifter (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .frame    (frame),
    .take     (m_tready),
    .status   (status),
    .busy     (busy),
    .byte_out (m_tdata)
  );

  assign m_tvalid = status.valid;
  assign m_tlast  = status.last;

endmodule
`default_nettype wire

// ----- src/plfs_frame_shifter.sv -----
`default_nettype none
module plfs_frame_shifter
  import plfs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire logic [FRAME_BITS-1:0] frame,
  input  wire logic                  take,
  output plfs_stream_t               status,
  output logic                       busy,
  output logic [7:0]                 byte_out
);

  logic [FRAME_BITS-1:0] frame_sr;
  logic [COUNT_W-1:0]    remaining;

  // byte-serial shift, most significant byte leaves first
  always_ff @(posedge clk) begin
    if (load) begin
      frame_sr <= frame;
    end else if (take && busy) begin
      frame_sr <= {frame_sr[FRAME_BITS-9:0], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (load) begin
      remaining <= COUNT_W'(FRAME_BYTES);
    end else if (take && busy) begin
      remaining <= remaining - COUNT_W'(1);
    end
  end

  assign busy         = (remaining != '0);
  assign byte_out     = frame_sr[FRAME_BITS-1 -: 8];
  assign status.valid = busy;
  assign status.last  = (remaining == COUNT_W'(1));

endmodule
`default_nettype wire

// ----- src/plfs_checker.sv -----
`default_nettype none
module plfs_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic       s_tuser,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast
);

  // a stalled byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output transaction changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while frame in flight");

  a_update_starts: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> m_tvalid && !m_tlast)
    else $error("update did not start frame");

  a_set_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> s_tready && !m_tvalid)
    else $error("set command produced output");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
    else $error("block not idle after last byte");

endmodule

bind pwm_led_frame_serializer_core plfs_checker u_plfs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
`default_nettype wire
